// ===== rtl/pbws_pkg.sv =====
// Package with the item types, result codes and push bundle of the wire stream parser.
package pbws_pkg;

  typedef enum logic [1:0] {
    KIND_VARINT  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_BAD_WIRE  = 2'd3
  } status_e;

  localparam logic [2:0] WIRE_VINT = 3'd0;
  localparam logic [2:0] WIRE_I64  = 3'd1;
  localparam logic [2:0] WIRE_LEN  = 3'd2;
  localparam logic [2:0] WIRE_I32  = 3'd5;

  localparam logic [7:0] CFG_KNOWN_MASK  = 8'd0;
  localparam logic [7:0] CFG_BYTES_MASK  = 8'd1;
  localparam logic [7:0] CFG_ZIGZAG_MASK = 8'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        last_in_field;
    logic [1:0]  status;
    logic        last_of_run;
  } res_item_t;

  // Results that one accepted item hands to the output queue.
  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } push_t;

endpackage

// ===== rtl/pbws_core.sv =====
// Parser state registers and the per-byte decode logic of the wire stream parser.
module pbws_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  pbws_pkg::in_item_t item_i,
  input  logic [31:0]      known_mask_i,
  input  logic [31:0]      bytes_mask_i,
  input  logic [31:0]      zigzag_mask_i,
  output pbws_pkg::push_t  push_o
);
  import pbws_pkg::*;

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [4:0]  field_q, field_d;
  logic        sel_q, sel_d;
  logic [2:0]  wire_q, wire_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  err_q, err_d;

  logic [63:0] acc_or;
  logic [6:0]  shift_sum;
  logic [63:0] rem_dec;
  logic [31:0] zz;
  logic        byte_vld;
  res_item_t   byte_res;
  res_item_t   done_res;
  logic [1:0]  done_st;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    shift_d  = shift_q;
    field_d  = field_q;
    sel_d    = sel_q;
    wire_d   = wire_q;
    remain_d = remain_q;
    err_d    = err_q;
    byte_vld = 1'b0;
    byte_res = '0;
    done_res = '0;
    done_st  = ST_VALID;
    push_o   = '0;

    // In the varint phases the shift never exceeds 63, so six bits index it.
    acc_or    = acc_q | ({57'd0, item_i.byte_value[6:0]} << shift_q[5:0]);
    shift_sum = shift_q + 7'd7;
    rem_dec   = (remain_q == 64'd0) ? 64'd0 : remain_q - 64'd1;
    zz        = acc_or[31:0];

    byte_res.field_number = field_q;
    byte_res.wire_kind    = wire_q;

    if (item_i.byte_present) begin
      unique case (phase_q)
        PH_TAG, PH_VALUE, PH_LENGTH: begin
          if (item_i.byte_value[7]) begin
            acc_d   = acc_or;
            shift_d = shift_sum;
            if (shift_sum[6]) begin
              err_d   = ST_TOO_LONG;
              phase_d = PH_ERROR;
            end
          end else begin
            acc_d   = 64'd0;
            shift_d = 7'd0;
            if (phase_q == PH_TAG) begin
              field_d = acc_or[7:3];
              wire_d  = acc_or[2:0];
              sel_d   = 1'b0;
              if (acc_or[63:8] == 56'd0 && known_mask_i[acc_or[7:3]]) begin
                sel_d = bytes_mask_i[acc_or[7:3]] ? (acc_or[2:0] == WIRE_LEN)
                                                  : (acc_or[2:0] == WIRE_VINT);
              end
              case (acc_or[2:0])
                WIRE_VINT: phase_d = PH_VALUE;
                WIRE_LEN:  phase_d = PH_LENGTH;
                WIRE_I64: begin
                  remain_d = 64'd8;
                  phase_d  = PH_PAYLOAD;
                end
                WIRE_I32: begin
                  remain_d = 64'd4;
                  phase_d  = PH_PAYLOAD;
                end
                default: begin
                  err_d   = ST_BAD_WIRE;
                  phase_d = PH_ERROR;
                end
              endcase
            end else if (phase_q == PH_VALUE) begin
              byte_vld             = sel_q;
              byte_res.result_kind = KIND_VARINT;
              byte_res.field_value = zigzag_mask_i[field_q]
                                   ? {32'd0, (zz >> 1) ^ {32{zz[0]}}} : acc_or;
              phase_d              = PH_TAG;
            end else begin
              byte_vld             = sel_q;
              byte_res.result_kind = KIND_LENGTH;
              byte_res.field_value = acc_or;
              if (acc_or == 64'd0) begin
                phase_d = PH_TAG;
              end else begin
                remain_d = acc_or;
                phase_d  = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          byte_vld               = sel_q;
          byte_res.result_kind   = KIND_PAYLOAD;
          byte_res.payload_byte  = item_i.byte_value;
          byte_res.last_in_field = (remain_q == 64'd1);
          remain_d               = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_d = PH_TAG;
          end
        end
        default: begin
        end
      endcase
    end

    // Status looks at the state the byte of the same item left behind.
    done_st = err_d;
    if (err_d == ST_VALID && (phase_d != PH_TAG || shift_d != 7'd0)) begin
      done_st = ST_TRUNCATED;
    end
    done_res.result_kind = KIND_DONE;
    done_res.status      = done_st;
    done_res.last_of_run = 1'b1;

    if (item_i.end_of_message) begin
      phase_d  = PH_TAG;
      acc_d    = 64'd0;
      shift_d  = 7'd0;
      field_d  = 5'd0;
      sel_d    = 1'b0;
      wire_d   = 3'd0;
      remain_d = 64'd0;
      err_d    = ST_VALID;
    end

    if (accept_i) begin
      if (byte_vld) begin
        push_o.first             = byte_res;
        push_o.first.last_of_run = !item_i.end_of_message;
        push_o.second            = done_res;
        push_o.count             = item_i.end_of_message ? 2'd2 : 2'd1;
      end else if (item_i.end_of_message) begin
        push_o.first = done_res;
        push_o.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      acc_q    <= 64'd0;
      shift_q  <= 7'd0;
      field_q  <= 5'd0;
      sel_q    <= 1'b0;
      wire_q   <= 3'd0;
      remain_q <= 64'd0;
      err_q    <= ST_VALID;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      field_q  <= field_d;
      sel_q    <= sel_d;
      wire_q   <= wire_d;
      remain_q <= remain_d;
      err_q    <= err_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_in_error_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_VALID) |-> (phase_q == PH_ERROR))
    else $error("error status set outside the error phase");

  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.end_of_message) |=> (phase_q == PH_TAG && shift_q == 7'd0))
    else $error("parse state not cleared after end of message");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_ERROR) |-> (shift_q <= 7'd63))
    else $error("varint shift out of range outside the error phase");
`endif

endmodule

// ===== rtl/pbws_out_fifo.sv =====
// Four-entry result queue: up to two results in, one out per unstalled cycle.
module pbws_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbws_pkg::push_t     push_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pbws_pkg::res_item_t out_data_o
);
  import pbws_pkg::*;

  res_item_t  mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room for a two-result request is required before any request is taken.
  assign full_o      = (cnt_q > 3'd2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {1'b0, push_i.count} - {2'd0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> !full_o)
    else $error("result pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("queue count out of range");

  a_pair_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd2) |-> (push_i.second.result_kind == KIND_DONE
                                && !push_i.first.last_of_run))
    else $error("second result of a request is not a done result");
`endif

endmodule

// ===== rtl/protobuf_wire_stream_parser_top.sv =====
// The results of an accepted request are registered in the output queue of four entries.
// The parser takes one request per cycle while each yields at most one result and the
// output is not stalled; a request with a byte result and a done result yields two, and
// the one-result-per-cycle queue stalls the input once it holds more than two results.
// Reset (asynchronous, active low) restores the masks and parse state and empties the queue.
// Top level of the wire stream parser: configuration registers, decode core and result queue.
module protobuf_wire_stream_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pbws_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pbws_pkg::res_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import pbws_pkg::*;

  logic [31:0] known_mask_q;
  logic [31:0] bytes_mask_q;
  logic [31:0] zigzag_mask_q;
  logic        accept;
  logic        full;
  push_t       push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_mask_q  <= 32'h0000_00FE;
      bytes_mask_q  <= 32'h0000_00F6;
      zigzag_mask_q <= 32'h0000_0008;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KNOWN_MASK:  known_mask_q  <= cfg_data_i;
        CFG_BYTES_MASK:  bytes_mask_q  <= cfg_data_i;
        CFG_ZIGZAG_MASK: zigzag_mask_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pbws_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_data_i),
    .known_mask_i  (known_mask_q),
    .bytes_mask_i  (bytes_mask_q),
    .zigzag_mask_i (zigzag_mask_q),
    .push_o        (push)
  );

  pbws_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
